>>> hdl/cbc_pkg.sv
`timescale 1ns / 1ps

package cbc_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MEM_ADDR_W = 21;
    localparam int ROM_BANK_W = 7;
    localparam int RAM_BANK_W = 2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MBC1 = 2'd1;
    localparam logic [1:0] KIND_MBC2 = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_ROM_RD  = 2'd1;
    localparam logic [1:0] TGT_RAM_RD  = 2'd2;
    localparam logic [1:0] TGT_RAM_WR  = 2'd3;

    // address regions below 0x8000, taken from bus_address[14:13]
    localparam logic [1:0] RGN_RAM_EN   = 2'd0;
    localparam logic [1:0] RGN_ROM_LO   = 2'd1;
    localparam logic [1:0] RGN_BANK_HI  = 2'd2;
    localparam logic [1:0] RGN_MODE     = 2'd3;

    localparam logic [3:0] RAM_ENABLE_CODE  = 4'hA;
    localparam logic [3:0] RAM_DISABLE_CODE = 4'h0;
    localparam logic [2:0] RAM_WINDOW_TOP   = 3'b101;

    typedef struct packed {
        logic                  op;
        logic [ADDR_W-1:0]     bus_address;
        logic [DATA_W-1:0]     write_byte;
    } access_t;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enabled;
        logic                  rom_bank_mode;
    } bank_state_t;

endpackage

>>> hdl/cbc_bank_regs.sv
`timescale 1ns / 1ps

module cbc_bank_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           kind,
    input  logic                 commit,
    input  cbc_pkg::access_t     acc,
    output cbc_pkg::bank_state_t state
);
    import cbc_pkg::*;

    bank_state_t state_reg;
    bank_state_t state_next;
    logic        mbc1;
    logic        mbc2;
    logic [1:0]  region;

    function automatic logic [ROM_BANK_W-1:0] nonzero_bank(input logic [ROM_BANK_W-1:0] b);
        nonzero_bank = (b == '0) ? ROM_BANK_W'(1) : b;
    endfunction

    assign mbc1   = (kind == KIND_MBC1);
    assign mbc2   = (kind == KIND_MBC2);
    assign region = acc.bus_address[14:13];

    always_comb begin
        state_next = state_reg;
        if (commit && acc.op == OP_WRITE && !acc.bus_address[15]) begin
            case (region)
                RGN_RAM_EN: begin
                    if ((mbc1 || mbc2) && !(mbc2 && acc.bus_address[4])) begin
                        if (acc.write_byte[3:0] == RAM_ENABLE_CODE) begin
                            state_next.ram_enabled = 1'b1;
                        end else if (acc.write_byte[3:0] == RAM_DISABLE_CODE) begin
                            state_next.ram_enabled = 1'b0;
                        end
                    end
                end
                RGN_ROM_LO: begin
                    if (mbc2) begin
                        state_next.rom_bank = nonzero_bank({3'b000, acc.write_byte[3:0]});
                    end else if (mbc1) begin
                        state_next.rom_bank =
                            nonzero_bank({state_reg.rom_bank[6:5], acc.write_byte[4:0]});
                    end
                end
                RGN_BANK_HI: begin
                    if (mbc1) begin
                        if (state_reg.rom_bank_mode) begin
                            state_next.rom_bank =
                                nonzero_bank({acc.write_byte[1:0], state_reg.rom_bank[4:0]});
                        end else begin
                            state_next.ram_bank = acc.write_byte[1:0];
                        end
                    end
                end
                RGN_MODE: begin
                    if (mbc1) begin
                        state_next.rom_bank_mode = !acc.write_byte[0];
                        if (!acc.write_byte[0]) begin
                            state_next.ram_bank = '0;
                        end
                    end
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.rom_bank      <= ROM_BANK_W'(1);
            state_reg.ram_bank      <= '0;
            state_reg.ram_enabled   <= 1'b0;
            state_reg.rom_bank_mode <= 1'b0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

>>> hdl/cartridge_bank_controller.sv
`timescale 1ns / 1ps
// Cartridge bank controller (MBC1 / MBC2 style) for a CPU memory bus.
// Input channel s_*: one bus access per transaction (op, bus_address, write_byte).
// Result channel m_*: one result per access (target, mem_address, data_out), in order.
// cfg_we/cfg_wdata write controller_kind; write only while the block is idle.
// An accepted access passes the input register, then the result register, before
// its result appears on m_*. Throughput: one transaction per cycle unless the
// receiver stalls; both channels may move in the same cycle.
// Bank registers change as a write leaves the input register, so later accesses
// always see the effect of earlier ones.
// When the receiver stalls, the result register holds; the input register still
// takes one more access, then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): both stages empty, controller_kind = none,
// ROM bank 1, RAM bank 0, RAM disabled, RAM banking mode.

module cartridge_bank_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [cbc_pkg::ADDR_W-1:0]    s_bus_address,
    input  logic [cbc_pkg::DATA_W-1:0]    s_write_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_target,
    output logic [cbc_pkg::MEM_ADDR_W-1:0] m_mem_address,
    output logic [cbc_pkg::DATA_W-1:0]    m_data_out
);
    import cbc_pkg::*;

    logic [1:0]              kind_reg;
    logic                    in_valid_reg;
    access_t                 in_reg;
    logic                    out_valid_reg;
    logic [1:0]              target_reg;
    logic [MEM_ADDR_W-1:0]   mem_address_reg;
    logic [DATA_W-1:0]       data_out_reg;

    logic                    advance;
    logic                    commit;
    bank_state_t             bank;
    logic                    banking;
    logic [1:0]              target_next;
    logic [MEM_ADDR_W-1:0]   mem_address_next;
    logic [DATA_W-1:0]       data_out_next;

    assign advance = !out_valid_reg || m_ready;
    assign commit  = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign banking = (kind_reg == KIND_MBC1) || (kind_reg == KIND_MBC2);

    cbc_bank_regs u_bank_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .kind    (kind_reg),
        .commit  (commit),
        .acc     (in_reg),
        .state   (bank)
    );

    always_comb begin
        target_next      = TGT_NONE;
        mem_address_next = '0;
        data_out_next    = '0;
        if (!in_reg.bus_address[15]) begin
            if (in_reg.op == OP_READ) begin
                target_next = TGT_ROM_RD;
                if (in_reg.bus_address[14] && banking) begin
                    mem_address_next = {bank.rom_bank, in_reg.bus_address[13:0]};
                end else begin
                    mem_address_next = MEM_ADDR_W'(in_reg.bus_address);
                end
            end
        end else if (in_reg.bus_address[15:13] == RAM_WINDOW_TOP) begin
            if (in_reg.op == OP_READ) begin
                target_next      = TGT_RAM_RD;
                mem_address_next = {6'b0, bank.ram_bank, in_reg.bus_address[12:0]};
            end else if (bank.ram_enabled) begin
                target_next      = TGT_RAM_WR;
                mem_address_next = {6'b0, bank.ram_bank, in_reg.bus_address[12:0]};
                data_out_next    = in_reg.write_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= KIND_NONE;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                kind_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.op          <= s_op;
            in_reg.bus_address <= s_bus_address;
            in_reg.write_byte  <= s_write_byte;
        end
        if (commit) begin
            target_reg      <= target_next;
            mem_address_reg <= mem_address_next;
            data_out_reg    <= data_out_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_target      = target_reg;
    assign m_mem_address = mem_address_reg;
    assign m_data_out    = data_out_reg;

endmodule
